// ===== hdl/seqcd_pkg.sv =====
// ----------------------------------------------------------------------------
// seqcd_pkg: shared types and constants of the sequence command decoder
// Opcodes, event kinds, register indexes, field widths and the records
// passed from the parser through the command queue to the event formatter.
// ----------------------------------------------------------------------------
package seqcd_pkg;

	localparam int VARLEN_MAX_BYTES = 4;
	localparam int MAX_FIXED_ARGS   = 5;
	localparam int MAX_COUNT        = (1 + VARLEN_MAX_BYTES > MAX_FIXED_ARGS) ?
		1 + VARLEN_MAX_BYTES : MAX_FIXED_ARGS;
	localparam int ARG_COUNT_W      = $clog2(MAX_COUNT + 1);
	localparam int ARG_IDX_W        = $clog2(MAX_FIXED_ARGS);
	localparam int NFIX_W           = $clog2(MAX_FIXED_ARGS + 1);
	localparam int QUEUE_DEPTH      = 2;

	localparam int BYTE_W   = 8;
	localparam int ADDR_W   = 32;
	localparam int KIND_W   = 6;
	localparam int LENGTH_W = 4;
	localparam int WIDE_W   = 17;
	localparam int EXTRA_W  = 16;
	localparam int ACC_W    = 28;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 168;

	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DATA_BASE        = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_NOTEWAIT_DEFAULT = 1'd1;
	localparam logic [ADDR_W-1:0]      DATA_BASE_RESET      = 32'h0000_001C;
	localparam logic                   NOTEWAIT_RESET       = 1'b1;
	localparam logic [ADDR_W-1:0]      CALL_LENGTH          = 32'd4;

	localparam logic [7:0] OP_REST       = 8'h80;
	localparam logic [7:0] OP_PROGRAM    = 8'h81;
	localparam logic [7:0] OP_OPEN_TRACK = 8'h93;
	localparam logic [7:0] OP_JUMP       = 8'h94;
	localparam logic [7:0] OP_CALL       = 8'h95;
	localparam logic [7:0] OP_RANDOM     = 8'hA0;
	localparam logic [7:0] OP_VAR_CMD    = 8'hA1;
	localparam logic [7:0] OP_IF         = 8'hA2;
	localparam logic [7:0] OP_VAR_FIRST  = 8'hB0;
	localparam logic [7:0] OP_VAR_HOLE   = 8'hB7;
	localparam logic [7:0] OP_VAR_LAST   = 8'hBD;
	localparam logic [7:0] OP_C0         = 8'hC0;
	localparam logic [7:0] OP_TRANSPOSE  = 8'hC3;
	localparam logic [7:0] OP_PITCH_BEND = 8'hC4;
	localparam logic [7:0] OP_NOTEWAIT   = 8'hC7;
	localparam logic [7:0] OP_CF         = 8'hCF;
	localparam logic [7:0] OP_D0         = 8'hD0;
	localparam logic [7:0] OP_D6         = 8'hD6;
	localparam logic [7:0] OP_E0         = 8'hE0;
	localparam logic [7:0] OP_TEMPO      = 8'hE1;
	localparam logic [7:0] OP_SWEEP      = 8'hE3;
	localparam logic [7:0] OP_FC         = 8'hFC;
	localparam logic [7:0] OP_RETURN     = 8'hFD;
	localparam logic [7:0] OP_ALLOC      = 8'hFE;
	localparam logic [7:0] OP_END        = 8'hFF;

	localparam logic [KIND_W-1:0] KIND_NOTE       = 6'd0;
	localparam logic [KIND_W-1:0] KIND_REST       = 6'd1;
	localparam logic [KIND_W-1:0] KIND_PROGRAM    = 6'd2;
	localparam logic [KIND_W-1:0] KIND_OPEN_TRACK = 6'd3;
	localparam logic [KIND_W-1:0] KIND_JUMP       = 6'd4;
	localparam logic [KIND_W-1:0] KIND_CALL       = 6'd5;
	localparam logic [KIND_W-1:0] KIND_RANDOM     = 6'd6;
	localparam logic [KIND_W-1:0] KIND_VAR_CMD    = 6'd7;
	localparam logic [KIND_W-1:0] KIND_IF         = 6'd8;
	localparam logic [KIND_W-1:0] KIND_VAR_OP     = 6'd9;
	localparam logic [KIND_W-1:0] KIND_CMD_C0     = 6'd10;
	localparam logic [KIND_W-1:0] KIND_CMD_D0     = 6'd26;
	localparam logic [KIND_W-1:0] KIND_CMD_D6     = 6'd32;
	localparam logic [KIND_W-1:0] KIND_CMD_E0     = 6'd33;
	localparam logic [KIND_W-1:0] KIND_TEMPO      = 6'd34;
	localparam logic [KIND_W-1:0] KIND_SWEEP      = 6'd35;
	localparam logic [KIND_W-1:0] KIND_CMD_FC     = 6'd36;
	localparam logic [KIND_W-1:0] KIND_RETURN     = 6'd37;
	localparam logic [KIND_W-1:0] KIND_ALLOC      = 6'd38;
	localparam logic [KIND_W-1:0] KIND_END        = 6'd39;
	localparam logic [KIND_W-1:0] KIND_UNKNOWN    = 6'd40;

	typedef logic [MAX_FIXED_ARGS-1:0][BYTE_W-1:0] arg_vec_t;

	typedef struct packed {
		logic [BYTE_W-1:0]      opcode;
		logic [ADDR_W-1:0]      begin_addr;
		logic [ARG_COUNT_W-1:0] count;
		arg_vec_t               args;
		logic [ACC_W-1:0]       accum;
		logic                   note_wait;
		logic [ADDR_W-1:0]      ret_addr;
	} cmd_t;

	// wide_value and extra_value hold two's complement bit patterns
	typedef struct packed {
		logic [KIND_W-1:0]   event_kind;
		logic [ADDR_W-1:0]   event_begin;
		logic [LENGTH_W-1:0] event_length;
		logic [BYTE_W-1:0]   small_value;
		logic [WIDE_W-1:0]   wide_value;
		logic [EXTRA_W-1:0]  extra_value;
		logic [ACC_W-1:0]    duration;
		logic [ACC_W-1:0]    time_advance;
		logic                redirect;
		logic [ADDR_W-1:0]   redirect_target;
		logic                track_stop;
		logic                is_loop;
	} evt_t;

endpackage

// ===== hdl/seqcd_front.sv =====
// ----------------------------------------------------------------------------
// seqcd_front: byte parser
// Takes one stream byte per cycle while the command queue is not full, tracks the command in progress, collects
// fixed arguments and the variable-length value, and pushes a command record
// when the last byte of a command arrives. Holds return address and note-wait.
// ----------------------------------------------------------------------------
module seqcd_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [seqcd_pkg::BYTE_W-1:0] data_byte,
	input  logic [seqcd_pkg::ADDR_W-1:0] byte_address,
	input  logic                       track_start,
	input  logic                       notewait_default,
	input  logic                       q_ready,
	output logic                       push,
	output seqcd_pkg::cmd_t            cmd
);

	typedef struct packed {
		logic [seqcd_pkg::NFIX_W-1:0] nfix;
		logic                         vl;
	} argspec_t;

	function automatic argspec_t fixed_args(input logic [7:0] op);
		argspec_t s;
		s = '0;
		if (op < seqcd_pkg::OP_REST) begin
			s.nfix = seqcd_pkg::NFIX_W'(1);
			s.vl   = 1'b1;
		end else if (op == seqcd_pkg::OP_REST || op == seqcd_pkg::OP_PROGRAM) begin
			s.vl = 1'b1;
		end else if (op == seqcd_pkg::OP_OPEN_TRACK) begin
			s.nfix = seqcd_pkg::NFIX_W'(4);
		end else if (op == seqcd_pkg::OP_JUMP || op == seqcd_pkg::OP_CALL) begin
			s.nfix = seqcd_pkg::NFIX_W'(3);
		end else if (op == seqcd_pkg::OP_RANDOM) begin
			s.nfix = seqcd_pkg::NFIX_W'(5);
		end else if (op == seqcd_pkg::OP_VAR_CMD) begin
			s.nfix = seqcd_pkg::NFIX_W'(2);
		end else if (op >= seqcd_pkg::OP_VAR_FIRST && op <= seqcd_pkg::OP_VAR_LAST &&
				op != seqcd_pkg::OP_VAR_HOLE) begin
			s.nfix = seqcd_pkg::NFIX_W'(3);
		end else if (op >= seqcd_pkg::OP_C0 && op <= seqcd_pkg::OP_D6) begin
			s.nfix = seqcd_pkg::NFIX_W'(1);
		end else if (op == seqcd_pkg::OP_E0 || op == seqcd_pkg::OP_TEMPO ||
				op == seqcd_pkg::OP_SWEEP || op == seqcd_pkg::OP_ALLOC) begin
			s.nfix = seqcd_pkg::NFIX_W'(2);
		end
		return s;
	endfunction

	logic [seqcd_pkg::BYTE_W-1:0]      opcode_q;
	logic [seqcd_pkg::ADDR_W-1:0]      begin_q;
	logic [seqcd_pkg::ARG_COUNT_W-1:0] cnt_q;
	logic [seqcd_pkg::BYTE_W-1:0]      arg_q [seqcd_pkg::MAX_FIXED_ARGS];
	logic [seqcd_pkg::ACC_W-1:0]       acc_q;
	logic [seqcd_pkg::ADDR_W-1:0]      ret_q;
	logic                              nw_q;
	logic                              in_cmd_q;

	logic                              accept;
	logic                              in_cmd;
	logic [seqcd_pkg::ADDR_W-1:0]      ret_eff;
	logic                              nw_eff;
	argspec_t                          spec;
	logic [seqcd_pkg::ARG_COUNT_W-1:0] nfix_ext;
	logic [seqcd_pkg::ARG_COUNT_W-1:0] cnt_nxt;
	logic                              arg_wr;
	logic [seqcd_pkg::ACC_W-1:0]       acc_nxt;
	seqcd_pkg::arg_vec_t               arg_d;
	logic                              done;

	assign in_ready = q_ready;
	assign accept   = in_valid && in_ready;
	assign in_cmd   = in_cmd_q && !track_start;
	assign ret_eff  = track_start ? '0 : ret_q;
	assign nw_eff   = track_start ? notewait_default : nw_q;

	always_comb begin
		spec     = fixed_args(in_cmd ? opcode_q : data_byte);
		nfix_ext = seqcd_pkg::ARG_COUNT_W'(spec.nfix);
		cnt_nxt  = cnt_q + seqcd_pkg::ARG_COUNT_W'(1);
		arg_wr   = in_cmd && (cnt_q < nfix_ext);
		acc_nxt  = acc_q;
		if (!in_cmd) begin
			done = (spec.nfix == '0) && !spec.vl;
		end else if (arg_wr) begin
			done = (cnt_nxt == nfix_ext) && !spec.vl;
		end else begin
			acc_nxt = {acc_q[seqcd_pkg::ACC_W-8:0], data_byte[6:0]};
			done    = !data_byte[7] ||
				((cnt_nxt - nfix_ext) >= seqcd_pkg::ARG_COUNT_W'(seqcd_pkg::VARLEN_MAX_BYTES));
		end
		for (int i = 0; i < seqcd_pkg::MAX_FIXED_ARGS; i++) begin
			arg_d[i] = (arg_wr && cnt_q[seqcd_pkg::ARG_IDX_W-1:0] == seqcd_pkg::ARG_IDX_W'(i)) ?
				data_byte : arg_q[i];
		end
	end

	always_comb begin
		cmd.opcode     = in_cmd ? opcode_q : data_byte;
		cmd.begin_addr = in_cmd ? begin_q : byte_address;
		cmd.count      = in_cmd ? cnt_nxt : '0;
		cmd.args       = arg_d;
		cmd.accum      = in_cmd ? acc_nxt : '0;
		cmd.note_wait  = nw_eff;
		cmd.ret_addr   = ret_eff;
	end

	assign push = accept && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opcode_q <= '0;
			begin_q  <= '0;
			cnt_q    <= '0;
			acc_q    <= '0;
			ret_q    <= '0;
			nw_q     <= seqcd_pkg::NOTEWAIT_RESET;
			in_cmd_q <= 1'b0;
		end else if (accept) begin
			opcode_q <= cmd.opcode;
			begin_q  <= cmd.begin_addr;
			cnt_q    <= cmd.count;
			acc_q    <= cmd.accum;
			in_cmd_q <= !done;
			if (done && cmd.opcode == seqcd_pkg::OP_CALL) begin
				ret_q <= cmd.begin_addr + seqcd_pkg::CALL_LENGTH;
			end else begin
				ret_q <= ret_eff;
			end
			if (done && cmd.opcode == seqcd_pkg::OP_NOTEWAIT) begin
				nw_q <= arg_d[0] != '0;
			end else begin
				nw_q <= nw_eff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < seqcd_pkg::MAX_FIXED_ARGS; i++) begin
				arg_q[i] <= arg_d[i];
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_cmd_q |-> cnt_q <= seqcd_pkg::ARG_COUNT_W'(seqcd_pkg::MAX_COUNT))
		else $error("argument count beyond longest command");
`endif

endmodule

// ===== hdl/seqcd_queue.sv =====
// ----------------------------------------------------------------------------
// seqcd_queue: command queue
// Short register queue of finished command records between the parser and
// the event formatter; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module seqcd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  seqcd_pkg::cmd_t push_cmd,
	output logic            not_full,
	input  logic            pop,
	output logic            not_empty,
	output seqcd_pkg::cmd_t pop_cmd
);

	localparam int QPTR_W   = (seqcd_pkg::QUEUE_DEPTH > 1) ? $clog2(seqcd_pkg::QUEUE_DEPTH) : 1;
	localparam int QCOUNT_W = $clog2(seqcd_pkg::QUEUE_DEPTH + 1);

	seqcd_pkg::cmd_t     entry_q [seqcd_pkg::QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCOUNT_W-1:0] count_q;

	assign not_full  = count_q != QCOUNT_W'(seqcd_pkg::QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign pop_cmd   = entry_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(seqcd_pkg::QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCOUNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCOUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q < QCOUNT_W'(seqcd_pkg::QUEUE_DEPTH))
		else $error("push into full command queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty command queue");
`endif

endmodule

// ===== hdl/seqcd_back.sv =====
// ----------------------------------------------------------------------------
// seqcd_back: event formatter
// Pops command records, classifies the opcode, extracts parameters, computes
// time advance and redirects, and holds the event in the output register.
// ----------------------------------------------------------------------------
module seqcd_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  seqcd_pkg::cmd_t              q_cmd,
	output logic                         pop,
	input  logic [seqcd_pkg::ADDR_W-1:0] data_base,
	output logic                         out_valid,
	input  logic                         out_ready,
	output seqcd_pkg::evt_t              evt
);

	function automatic logic [seqcd_pkg::KIND_W-1:0] kind_of(input logic [7:0] op);
		logic [seqcd_pkg::KIND_W-1:0] k;
		k = seqcd_pkg::KIND_UNKNOWN;
		if (op < seqcd_pkg::OP_REST) k = seqcd_pkg::KIND_NOTE;
		else if (op == seqcd_pkg::OP_REST) k = seqcd_pkg::KIND_REST;
		else if (op == seqcd_pkg::OP_PROGRAM) k = seqcd_pkg::KIND_PROGRAM;
		else if (op == seqcd_pkg::OP_OPEN_TRACK) k = seqcd_pkg::KIND_OPEN_TRACK;
		else if (op == seqcd_pkg::OP_JUMP) k = seqcd_pkg::KIND_JUMP;
		else if (op == seqcd_pkg::OP_CALL) k = seqcd_pkg::KIND_CALL;
		else if (op == seqcd_pkg::OP_RANDOM) k = seqcd_pkg::KIND_RANDOM;
		else if (op == seqcd_pkg::OP_VAR_CMD) k = seqcd_pkg::KIND_VAR_CMD;
		else if (op == seqcd_pkg::OP_IF) k = seqcd_pkg::KIND_IF;
		else if (op >= seqcd_pkg::OP_VAR_FIRST && op <= seqcd_pkg::OP_VAR_LAST &&
				op != seqcd_pkg::OP_VAR_HOLE) k = seqcd_pkg::KIND_VAR_OP;
		else if (op >= seqcd_pkg::OP_C0 && op <= seqcd_pkg::OP_CF)
			k = seqcd_pkg::KIND_CMD_C0 + seqcd_pkg::KIND_W'(op - seqcd_pkg::OP_C0);
		else if (op >= seqcd_pkg::OP_D0 && op <= seqcd_pkg::OP_D6)
			k = seqcd_pkg::KIND_CMD_D0 + seqcd_pkg::KIND_W'(op - seqcd_pkg::OP_D0);
		else if (op == seqcd_pkg::OP_E0) k = seqcd_pkg::KIND_CMD_E0;
		else if (op == seqcd_pkg::OP_TEMPO) k = seqcd_pkg::KIND_TEMPO;
		else if (op == seqcd_pkg::OP_SWEEP) k = seqcd_pkg::KIND_SWEEP;
		else if (op == seqcd_pkg::OP_FC) k = seqcd_pkg::KIND_CMD_FC;
		else if (op == seqcd_pkg::OP_RETURN) k = seqcd_pkg::KIND_RETURN;
		else if (op == seqcd_pkg::OP_ALLOC) k = seqcd_pkg::KIND_ALLOC;
		else if (op == seqcd_pkg::OP_END) k = seqcd_pkg::KIND_END;
		return k;
	endfunction

	seqcd_pkg::evt_t evt_q;
	logic            out_valid_q;
	seqcd_pkg::evt_t evt_d;
	logic [15:0]     le16_0;
	logic [15:0]     le16_1;
	logic [15:0]     le16_3;
	logic [7:0]      a0;
	logic [seqcd_pkg::ADDR_W-1:0] jump_target;

	assign pop = q_valid && (!out_valid_q || out_ready);

	always_comb begin
		a0          = q_cmd.args[0];
		le16_0      = {q_cmd.args[1], q_cmd.args[0]};
		le16_1      = {q_cmd.args[2], q_cmd.args[1]};
		le16_3      = {q_cmd.args[4], q_cmd.args[3]};
		jump_target = {8'd0, q_cmd.args[2], q_cmd.args[1], q_cmd.args[0]} + data_base;

		evt_d              = '0;
		evt_d.event_kind   = kind_of(q_cmd.opcode);
		evt_d.event_begin  = q_cmd.begin_addr;
		evt_d.event_length = seqcd_pkg::LENGTH_W'(q_cmd.count) + seqcd_pkg::LENGTH_W'(1);
		case (evt_d.event_kind)
			seqcd_pkg::KIND_NOTE: begin
				evt_d.small_value  = q_cmd.opcode;
				evt_d.extra_value  = {8'd0, a0};
				evt_d.duration     = q_cmd.accum;
				evt_d.time_advance = q_cmd.note_wait ? q_cmd.accum : '0;
			end
			seqcd_pkg::KIND_REST: begin
				evt_d.duration     = q_cmd.accum;
				evt_d.time_advance = q_cmd.accum;
			end
			seqcd_pkg::KIND_PROGRAM: begin
				evt_d.duration = {20'd0, q_cmd.accum[7:0]};
			end
			seqcd_pkg::KIND_JUMP: begin
				evt_d.redirect        = 1'b1;
				evt_d.is_loop         = 1'b1;
				evt_d.redirect_target = jump_target;
			end
			seqcd_pkg::KIND_CALL: begin
				evt_d.redirect        = 1'b1;
				evt_d.redirect_target = jump_target;
			end
			seqcd_pkg::KIND_RANDOM: begin
				evt_d.small_value = a0;
				evt_d.wide_value  = {le16_1[15], le16_1};
				evt_d.extra_value = le16_3;
			end
			seqcd_pkg::KIND_VAR_CMD: begin
				evt_d.small_value = a0;
				evt_d.wide_value  = {9'd0, q_cmd.args[1]};
			end
			seqcd_pkg::KIND_VAR_OP: begin
				evt_d.small_value = a0;
				evt_d.wide_value  = {le16_1[15], le16_1};
				evt_d.extra_value = {8'd0, q_cmd.opcode - seqcd_pkg::OP_VAR_FIRST};
			end
			seqcd_pkg::KIND_CMD_E0, seqcd_pkg::KIND_TEMPO: begin
				evt_d.wide_value = {1'b0, le16_0};
			end
			seqcd_pkg::KIND_SWEEP: begin
				evt_d.wide_value = {le16_0[15], le16_0};
			end
			seqcd_pkg::KIND_RETURN: begin
				evt_d.redirect        = 1'b1;
				evt_d.redirect_target = q_cmd.ret_addr;
			end
			seqcd_pkg::KIND_END, seqcd_pkg::KIND_UNKNOWN: begin
				evt_d.track_stop = 1'b1;
			end
			default: begin
				if (evt_d.event_kind >= seqcd_pkg::KIND_CMD_C0 &&
						evt_d.event_kind <= seqcd_pkg::KIND_CMD_D6) begin
					evt_d.small_value = a0;
					if (q_cmd.opcode == seqcd_pkg::OP_TRANSPOSE) begin
						evt_d.wide_value = {{9{a0[7]}}, a0};
					end else if (q_cmd.opcode == seqcd_pkg::OP_PITCH_BEND) begin
						evt_d.wide_value = {{3{a0[7]}}, a0, 6'd0};
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			evt_q <= evt_d;
		end
	end

	assign out_valid = out_valid_q;
	assign evt       = evt_q;

`ifndef SYNTHESIS
	a_stop_no_redirect: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && evt_q.track_stop |-> !evt_q.redirect)
		else $error("stopping event carries a redirect");
	a_loop_is_redirect: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && evt_q.is_loop |-> evt_q.redirect &&
			evt_q.event_kind == seqcd_pkg::KIND_JUMP)
		else $error("loop flag without jump redirect");
`endif

endmodule

// ===== hdl/sequence_command_decoder_core.sv =====
// ----------------------------------------------------------------------------
// sequence_command_decoder_core: sequence track command decoder
// A command's last byte writes its record into the queue, whose head is then
// registered as the event. Throughput: one byte per cycle while the queue is
// not full, at most one event per cycle; parser registers update once per byte.
// Reset (arst_n low, asynchronous): parser idle, queue and output empty,
// data_base = 0x1C, notewait_default = 1; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sequence_command_decoder_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [seqcd_pkg::S_DATA_W-1:0]      s_tdata,  // data_byte, byte_address
	input  logic [0:0]                          s_tuser,  // track_start
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// event_begin, event_length, small_value, wide_value, extra_value, duration,
	// time_advance, redirect, redirect_target, is_loop, zero pad
	output logic [seqcd_pkg::M_DATA_W-1:0]      m_tdata,
	output logic [seqcd_pkg::KIND_W-1:0]        m_tuser,  // event_kind
	output logic                                m_tlast,  // track_stop
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [seqcd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [seqcd_pkg::ADDR_W-1:0]        cfg_data
);

	logic [seqcd_pkg::ADDR_W-1:0] data_base_q;
	logic                         notewait_default_q;

	logic            q_not_full;
	logic            q_not_empty;
	logic            push;
	logic            pop;
	seqcd_pkg::cmd_t push_cmd;
	seqcd_pkg::cmd_t pop_cmd;
	seqcd_pkg::evt_t evt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_base_q        <= seqcd_pkg::DATA_BASE_RESET;
			notewait_default_q <= seqcd_pkg::NOTEWAIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				seqcd_pkg::CFG_DATA_BASE: data_base_q <= cfg_data;
				seqcd_pkg::CFG_NOTEWAIT_DEFAULT: notewait_default_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	seqcd_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (s_tvalid),
		.in_ready         (s_tready),
		.data_byte        (s_tdata[7:0]),
		.byte_address     (s_tdata[39:8]),
		.track_start      (s_tuser[0]),
		.notewait_default (notewait_default_q),
		.q_ready          (q_not_full),
		.push             (push),
		.cmd              (push_cmd)
	);

	seqcd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.not_full  (q_not_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.pop_cmd   (pop_cmd)
	);

	seqcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_not_empty),
		.q_cmd     (pop_cmd),
		.pop       (pop),
		.data_base (data_base_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.evt       (evt)
	);

	assign m_tdata = {1'b0, evt.is_loop, evt.redirect_target, evt.redirect,
		evt.time_advance, evt.duration, evt.extra_value, evt.wide_value,
		evt.small_value, evt.event_length, evt.event_begin};
	assign m_tuser = evt.event_kind;
	assign m_tlast = evt.track_stop;

endmodule
